// ===== rtl/core/tbpf_pkg.sv =====
// tbpf_pkg: shared constants and types for the tile background pixel fetch
// used by tile_background_pixel_fetch and tbpf_coord; depends on nothing
`default_nettype none

package tbpf_pkg;

  localparam int RAM_BYTES     = 8192;
  localparam int BANK_DEPTH    = RAM_BYTES / 2;
  localparam int RAM_AW        = $clog2(RAM_BYTES);
  localparam int BANK_AW       = $clog2(BANK_DEPTH);
  localparam int SCREEN_WIDTH  = 160;
  localparam int WIN_X_OFFSET  = 7;
  localparam int SIGNED_OFFSET = 'h0800;  // 0x8800 block relative to 0x8000

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_IDX_W   = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LCDC       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_X   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL_Y   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_X   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_Y   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BG_PALETTE = 3'd5;

  localparam logic [7:0] LCDC_RESET       = 8'd145;
  localparam logic [7:0] BG_PALETTE_RESET = 8'd252;

  // lcdc bit positions
  localparam int LCDC_BG_MAP    = 3;
  localparam int LCDC_TILE_MODE = 4;
  localparam int LCDC_WIN_EN    = 5;
  localparam int LCDC_WIN_MAP   = 6;

  // item kinds carried in tuser
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_RENDER = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_MAP  = 3'b010,
    S_PIX  = 3'b100
  } state_t;

  // map lookup for one pixel
  typedef struct packed {
    logic [BANK_AW-1:0] map_idx;
    logic               map_bank;
    logic [2:0]         fine_x;
    logic [2:0]         fine_y;
  } coord_t;

endpackage

`default_nettype wire

// ===== rtl/core/tile_background_pixel_fetch.sv =====
// tile_background_pixel_fetch: top level, config registers, sequencer and video ram banks
// depends on tbpf_pkg, tbpf_ram, tbpf_coord
`default_nettype none

// Background and window pixel fetch over an 8 KiB video RAM held as two
// 4096-byte banks (even and odd addresses). A write transaction (tuser 0)
// stores one byte. A render transaction (tuser 1) reads the tile map byte,
// then reads both bitplane bytes of the tile row together from the two
// banks, then loads the palette shade into the output register; the two
// RAM reads depend on each other. Renders with a column at or beyond the
// screen width produce no output. A finished shade waits in the output
// register, and the next input is taken while it waits; only a second shade
// ready before the first is taken holds the block. Video RAM is not cleared
// at reset, so a render must only read bytes already written. Config writes
// must go in only while the block is idle; the block itself does not enforce it.
module tile_background_pixel_fetch (
  input  wire logic                                 clk,
  input  wire logic                                 rst_n,
  // ram_address[12:0], write_byte[20:13], column[28:21], line_number[36:29], zero pad
  input  wire logic [tbpf_pkg::IN_TDATA_W-1:0]      in_tdata,
  // opcode[0]
  input  wire logic                                 in_tuser,
  input  wire logic                                 in_tvalid,
  output      logic                                 in_tready,
  // shade[1:0], out_column[9:2], zero pad
  output      logic [tbpf_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output      logic                                 out_tvalid,
  input  wire logic                                 out_tready,
  input  wire logic                                 cfg_we,
  input  wire logic [tbpf_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [7:0]                           cfg_wdata
);

  localparam int AW = tbpf_pkg::BANK_AW;

  logic [7:0] lcdc_r, scroll_x_r, scroll_y_r, window_x_r, window_y_r, bg_palette_r;

  tbpf_pkg::state_t state_r, state_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic [1:0]       shade_r, shade_nxt;
  logic [7:0]       col_r, col_nxt;
  logic             map_bank_r, map_bank_nxt;
  logic [2:0]       fine_x_r, fine_x_nxt;
  logic [2:0]       fine_y_r, fine_y_nxt;

  logic [12:0] in_addr;
  logic [7:0]  in_wbyte, in_col, in_line;
  logic        accept, is_write, is_render;
  logic        load_out;

  tbpf_pkg::coord_t coord;

  logic          we_even, we_odd, re;
  logic [AW-1:0] raddr;
  logic [7:0]    rdata_even, rdata_odd;
  logic [7:0]    map_byte, tile_sel;
  logic [12:0]   tile_base;
  logic [AW-1:0] row_idx;
  logic [1:0]    pix_code;
  logic [7:0]    pal_shift;

  assign in_addr  = in_tdata[12:0];
  assign in_wbyte = in_tdata[20:13];
  assign in_col   = in_tdata[28:21];
  assign in_line  = in_tdata[36:29];

  assign in_tready = (state_r == tbpf_pkg::S_IDLE);
  assign accept    = in_tvalid && in_tready;
  assign is_write  = accept && (in_tuser == tbpf_pkg::OP_WRITE);
  assign is_render = accept && (in_tuser == tbpf_pkg::OP_RENDER)
                     && ({1'b0, in_col} < 9'(tbpf_pkg::SCREEN_WIDTH));

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lcdc_r       <= tbpf_pkg::LCDC_RESET;
      scroll_x_r   <= '0;
      scroll_y_r   <= '0;
      window_x_r   <= '0;
      window_y_r   <= '0;
      bg_palette_r <= tbpf_pkg::BG_PALETTE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        tbpf_pkg::REG_LCDC:       lcdc_r       <= cfg_wdata;
        tbpf_pkg::REG_SCROLL_X:   scroll_x_r   <= cfg_wdata;
        tbpf_pkg::REG_SCROLL_Y:   scroll_y_r   <= cfg_wdata;
        tbpf_pkg::REG_WINDOW_X:   window_x_r   <= cfg_wdata;
        tbpf_pkg::REG_WINDOW_Y:   window_y_r   <= cfg_wdata;
        tbpf_pkg::REG_BG_PALETTE: bg_palette_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  tbpf_coord u_coord (
    .column      (in_col),
    .line_number (in_line),
    .lcdc        (lcdc_r),
    .scroll_x    (scroll_x_r),
    .scroll_y    (scroll_y_r),
    .window_x    (window_x_r),
    .window_y    (window_y_r),
    .coord       (coord)
  );

  // tile row address from the map byte; rows are even so lo/hi share an index
  always_comb begin
    map_byte = map_bank_r ? rdata_odd : rdata_even;
    if (lcdc_r[tbpf_pkg::LCDC_TILE_MODE]) begin
      tile_sel  = map_byte;
      tile_base = {1'b0, tile_sel, 4'b0000};
    end else begin
      tile_sel  = map_byte ^ 8'h80;
      tile_base = {1'b0, tile_sel, 4'b0000} + 13'(tbpf_pkg::SIGNED_OFFSET);
    end
    row_idx = {tile_base[12:4], fine_y_r};
  end

  always_comb begin
    pix_code  = {rdata_odd[~fine_x_r], rdata_even[~fine_x_r]};
    pal_shift = bg_palette_r >> {pix_code, 1'b0};
  end

  always_comb begin
    we_even = is_write && !in_addr[0];
    we_odd  = is_write &&  in_addr[0];
    re      = 1'b0;
    raddr   = coord.map_idx;
    case (state_r)
      tbpf_pkg::S_IDLE: begin
        re    = is_render;
        raddr = coord.map_idx;
      end
      tbpf_pkg::S_MAP: begin
        re    = 1'b1;
        raddr = row_idx;
      end
      default: ;
    endcase
  end

  tbpf_ram #(.WIDTH(8), .DEPTH(tbpf_pkg::BANK_DEPTH)) u_ram_even (
    .clk   (clk),
    .we    (we_even),
    .waddr (in_addr[12:1]),
    .wdata (in_wbyte),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata_even)
  );

  tbpf_ram #(.WIDTH(8), .DEPTH(tbpf_pkg::BANK_DEPTH)) u_ram_odd (
    .clk   (clk),
    .we    (we_odd),
    .waddr (in_addr[12:1]),
    .wdata (in_wbyte),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata_odd)
  );

  // sequencer; ram read data holds while a finished shade waits for the output
  always_comb begin
    state_nxt      = state_r;
    map_bank_nxt   = map_bank_r;
    fine_x_nxt     = fine_x_r;
    fine_y_nxt     = fine_y_r;
    col_nxt        = col_r;
    shade_nxt      = shade_r;
    load_out       = 1'b0;
    case (state_r)
      tbpf_pkg::S_IDLE: begin
        if (is_render) begin
          map_bank_nxt = coord.map_bank;
          fine_x_nxt   = coord.fine_x;
          fine_y_nxt   = coord.fine_y;
          col_nxt      = in_col;
          state_nxt    = tbpf_pkg::S_MAP;
        end
      end
      tbpf_pkg::S_MAP: begin
        state_nxt = tbpf_pkg::S_PIX;
      end
      tbpf_pkg::S_PIX: begin
        if (!out_tvalid_r || out_tready) begin
          load_out  = 1'b1;
          shade_nxt = pal_shift[1:0];
          state_nxt = tbpf_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = tbpf_pkg::S_IDLE;
      end
    endcase
    if (load_out) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end else begin
      out_tvalid_nxt = out_tvalid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= tbpf_pkg::S_IDLE;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_tvalid_r <= out_tvalid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    map_bank_r <= map_bank_nxt;
    fine_x_r   <= fine_x_nxt;
    fine_y_r   <= fine_y_nxt;
    shade_r    <= shade_nxt;
    if (load_out) begin
      col_r <= col_r;
    end else begin
      col_r <= col_nxt;
    end
  end

  logic [7:0] out_col_r;

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_col_r <= col_r;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {6'b000000, out_col_r, shade_r};

endmodule

`default_nettype wire

// ===== rtl/core/tbpf_ram.sv =====
// tbpf_ram: generic single write port, single read port ram with registered read
// no dependencies
`default_nettype none

module tbpf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/tbpf_coord.sv =====
// tbpf_coord: picks window or background and forms the tile map address of a pixel
// depends on tbpf_pkg
`default_nettype none

module tbpf_coord (
  input  wire logic [7:0]     column,
  input  wire logic [7:0]     line_number,
  input  wire logic [7:0]     lcdc,
  input  wire logic [7:0]     scroll_x,
  input  wire logic [7:0]     scroll_y,
  input  wire logic [7:0]     window_x,
  input  wire logic [7:0]     window_y,
  output      tbpf_pkg::coord_t coord
);

  logic                              use_win;
  logic [7:0]                        x;
  logic [7:0]                        y;
  logic                              map_hi;
  logic [tbpf_pkg::RAM_AW-1:0]       map_addr;

  always_comb begin
    use_win = lcdc[tbpf_pkg::LCDC_WIN_EN]
              && (line_number >= window_y)
              && (({1'b0, column} + 9'(tbpf_pkg::WIN_X_OFFSET)) >= {1'b0, window_x});
    if (use_win) begin
      x      = column + 8'(tbpf_pkg::WIN_X_OFFSET) - window_x;
      y      = line_number - window_y;
      map_hi = lcdc[tbpf_pkg::LCDC_WIN_MAP];
    end else begin
      x      = column + scroll_x;
      y      = line_number + scroll_y;
      map_hi = lcdc[tbpf_pkg::LCDC_BG_MAP];
    end
    // 0x9800 / 0x9c00 relative to 0x8000, then 32 tiles per map row
    map_addr       = {2'b11, map_hi, y[7:3], x[7:3]};
    coord.map_idx  = map_addr[tbpf_pkg::RAM_AW-1:1];
    coord.map_bank = map_addr[0];
    coord.fine_x   = x[2:0];
    coord.fine_y   = y[2:0];
  end

endmodule

`default_nettype wire
